// ===== src/ua_pkg.sv =====
// shared constants, codes and types of the unit allocator with eviction
package ua_pkg;

  localparam int NUM_UNITS = 128;
  localparam int ID_BITS   = 8;
  localparam int IDX_W     = $clog2(NUM_UNITS);
  localparam int CNT_W     = $clog2(NUM_UNITS + 1);

  // request kinds
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_SIZE   = 2'd1;
  localparam logic [1:0] STAT_OWNER0 = 2'd2;

  // one table entry as seen by the statistics unit
  typedef struct packed {
    logic               clr;
    logic               vld;
    logic [ID_BITS-1:0] val;
  } ua_smp_t;

  // statistics gathered over one sweep of the table
  typedef struct packed {
    logic [CNT_W-1:0]   free;
    logic [CNT_W-1:0]   best;
    logic [CNT_W-1:0]   own;
    logic [ID_BITS-1:0] top;
  } ua_stats_t;

endpackage

// ===== src/ua_stats.sv =====
// running statistics over one sweep: free count, longest free run, owner count, top id
module ua_stats (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ua_pkg::ua_smp_t              smp_i,
  input  logic [ua_pkg::ID_BITS-1:0]   owner_id_i,
  output ua_pkg::ua_stats_t            stats_o
);

  logic [ua_pkg::CNT_W-1:0]   free_q, free_d;
  logic [ua_pkg::CNT_W-1:0]   best_q, best_d;
  logic [ua_pkg::CNT_W-1:0]   own_q, own_d;
  logic [ua_pkg::CNT_W-1:0]   run_q, run_d;
  logic [ua_pkg::ID_BITS-1:0] top_q, top_d;

  always_comb begin
    free_d = free_q;
    best_d = best_q;
    own_d  = own_q;
    run_d  = run_q;
    top_d  = top_q;
    if (smp_i.clr) begin
      free_d = '0;
      best_d = '0;
      own_d  = '0;
      run_d  = '0;
      top_d  = '0;
    end else if (smp_i.vld) begin
      if (smp_i.val == '0) begin
        free_d = free_q + 1'b1;
        run_d  = run_q + 1'b1;
        if (run_d > best_q) begin
          best_d = run_d;
        end
      end else begin
        run_d = '0;
        if (smp_i.val > top_q) begin
          top_d = smp_i.val;
        end
      end
      if (smp_i.val == owner_id_i) begin
        own_d = own_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
      best_q <= '0;
      own_q  <= '0;
      run_q  <= '0;
      top_q  <= '0;
    end else begin
      free_q <= free_d;
      best_q <= best_d;
      own_q  <= own_d;
      run_q  <= run_d;
      top_q  <= top_d;
    end
  end

  assign stats_o.free = free_q;
  assign stats_o.best = best_q;
  assign stats_o.own  = own_q;
  assign stats_o.top  = top_q;

endmodule

// ===== src/unit_allocator_with_eviction_unit.sv =====
// top level of the unit allocator with eviction: owner table, sweep sequencer, result register
//
// usage
// - input channel (in_valid_i / in_stall_o) takes one request word: req_type_i,
//   owner_id_i, request_size_i; a word is taken when in_valid_i is high and
//   in_stall_o is low
// - output channel (out_valid_o / out_stall_i) gives one result word per request:
//   status_o, free_units_o, largest_free_run_o, owner_units_o
// - one request at a time, the next taken in the cycle after the result word loads;
//   in_stall_o is low only while the sequencer is idle, so a word may wait in the output
// - every request is one or more sweeps over the owner memory, one entry a cycle
//   on a single read port, with a decide step between the sweeps of an allocate
// - release, clear, query and rejected allocates: one sweep
// - allocate: a scan sweep, one sweep per evicted owner, and a fill sweep;
//   evictions at most NUM_UNITS
// - reset clears the per-entry valid bits at once, so every unit reads free;
//   clear does the same when it is accepted, no clearing pass is needed
// - a stalled receiver holds the result word; the block may take the next
//   request meanwhile but will not finish it until the register drains
module unit_allocator_with_eviction_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] owner_id_i,
  input  logic [7:0] request_size_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] free_units_o,
  output logic [7:0] largest_free_run_o,
  output logic [7:0] owner_units_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DECIDE,
    ST_DONE
  } state_e;

  // what a sweep writes back into each entry
  typedef enum logic [1:0] {
    SW_NONE,   // read only
    SW_STRIP,  // free every unit held by the target owner
    SW_FILL    // hand the lowest free units to the requester
  } sweep_e;

  state_e                          state_q;
  sweep_e                          mode_q;
  logic                            last_q;     // this sweep ends the request
  logic [1:0]                      kind_q;
  logic [ua_pkg::ID_BITS-1:0]      id_q;
  logic [7:0]                      size_q;
  logic [ua_pkg::ID_BITS-1:0]      tgt_q;
  logic [ua_pkg::CNT_W-1:0]        remain_q;
  logic [1:0]                      stat_q;

  // sweep address issue and registered read pipeline
  logic                            iss_on_q;
  logic [ua_pkg::IDX_W-1:0]        iss_q;
  logic                            p_vld_q;
  logic [ua_pkg::IDX_W-1:0]        p_idx_q;

  // owner memory and per-entry valid bits (invalid entry reads as free)
  logic [ua_pkg::ID_BITS-1:0]      mem_q [ua_pkg::NUM_UNITS];
  logic [ua_pkg::NUM_UNITS-1:0]    vld_q;
  logic [ua_pkg::ID_BITS-1:0]      rd_q;
  logic                            ent_vld_q;

  // result register
  logic                            out_vld_q;
  logic [1:0]                      res_stat_q;
  logic [7:0]                      res_free_q;
  logic [7:0]                      res_run_q;
  logic [7:0]                      res_own_q;

  logic                            accept;
  logic                            start;
  logic                            sweep_end;
  logic                            load_out;
  logic                            clr_all;
  logic [ua_pkg::ID_BITS-1:0]      in_id;
  logic [ua_pkg::ID_BITS-1:0]      old_val;
  logic [ua_pkg::ID_BITS-1:0]      new_val;
  logic                            take_unit;
  logic                            evict_more;
  ua_pkg::ua_smp_t                 smp;
  ua_pkg::ua_stats_t               st;

  function automatic logic [7:0] sat8(input logic [ua_pkg::CNT_W-1:0] v);
    logic [7:0] r;
    if (32'(v) > 32'd255) begin
      r = 8'hFF;
    end else begin
      r = 8'(v);
    end
    return r;
  endfunction

  assign in_id      = ua_pkg::ID_BITS'(owner_id_i);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign clr_all    = accept && (req_type_i == ua_pkg::REQ_CLEAR);
  assign sweep_end  = p_vld_q && (p_idx_q == ua_pkg::IDX_W'(ua_pkg::NUM_UNITS - 1));
  assign load_out   = (state_q == ST_DONE) && (!out_vld_q || !out_stall_i);
  assign evict_more = (32'(st.free) < 32'(size_q)) && (st.top != '0);
  assign start      = accept || (state_q == ST_DECIDE);

  // new value of the entry under the write-back stage
  always_comb begin
    old_val   = ent_vld_q ? rd_q : '0;
    new_val   = old_val;
    take_unit = 1'b0;
    case (mode_q)
      SW_STRIP: begin
        if (old_val == tgt_q) begin
          new_val = '0;
        end
      end
      SW_FILL: begin
        if ((old_val == '0) && (remain_q != '0)) begin
          new_val   = id_q;
          take_unit = 1'b1;
        end
      end
      default: begin
        new_val = old_val;
      end
    endcase
  end

  assign smp.clr = start;
  assign smp.vld = p_vld_q;
  assign smp.val = new_val;

  ua_stats u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_i      (smp),
    .owner_id_i (id_q),
    .stats_o    (st)
  );

  // memory: registered read at the issue address, write-back in the following cycle
  always_ff @(posedge clk_i) begin
    rd_q      <= mem_q[iss_q];
    ent_vld_q <= vld_q[iss_q];
    if (p_vld_q) begin
      mem_q[p_idx_q] <= new_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_all) begin
      vld_q <= '0;
    end else if (p_vld_q) begin
      vld_q[p_idx_q] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= SW_NONE;
      last_q   <= 1'b0;
      kind_q   <= ua_pkg::REQ_QUERY;
      id_q     <= '0;
      size_q   <= '0;
      tgt_q    <= '0;
      remain_q <= '0;
      stat_q   <= ua_pkg::STAT_OK;
      iss_on_q <= 1'b0;
      iss_q    <= '0;
      p_vld_q  <= 1'b0;
      p_idx_q  <= '0;
    end else begin
      // address issue runs for one sweep once started
      p_vld_q <= iss_on_q;
      p_idx_q <= iss_q;
      if (start) begin
        iss_on_q <= 1'b1;
        iss_q    <= '0;
      end else if (iss_on_q) begin
        if (iss_q == ua_pkg::IDX_W'(ua_pkg::NUM_UNITS - 1)) begin
          iss_on_q <= 1'b0;
        end
        iss_q <= iss_q + 1'b1;
      end
      if (p_vld_q && take_unit) begin
        remain_q <= remain_q - 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SWEEP;
            kind_q  <= req_type_i;
            id_q    <= in_id;
            size_q  <= request_size_i;
            tgt_q   <= in_id;
            stat_q  <= ua_pkg::STAT_OK;
            mode_q  <= SW_NONE;
            last_q  <= 1'b1;
            case (req_type_i)
              ua_pkg::REQ_ALLOC: begin
                if (32'(request_size_i) > 32'(ua_pkg::NUM_UNITS)) begin
                  stat_q <= ua_pkg::STAT_SIZE;
                end else if (in_id == '0) begin
                  stat_q <= ua_pkg::STAT_OWNER0;
                end else begin
                  last_q <= 1'b0;  // scan first, then evict and fill
                end
              end
              ua_pkg::REQ_RELEASE: begin
                mode_q <= SW_STRIP;
              end
              default: begin
                mode_q <= SW_NONE;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (sweep_end) begin
            state_q <= last_q ? ST_DONE : ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state_q <= ST_SWEEP;
          if (evict_more) begin
            mode_q <= SW_STRIP;
            tgt_q  <= st.top;
            last_q <= 1'b0;
          end else begin
            mode_q   <= SW_FILL;
            remain_q <= ua_pkg::CNT_W'(size_q);
            last_q   <= 1'b1;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_stat_q <= stat_q;
      res_free_q <= sat8(st.free);
      res_run_q  <= sat8(st.best);
      res_own_q  <= sat8(st.own);
    end
  end

  assign out_valid_o        = out_vld_q;
  assign status_o           = res_stat_q;
  assign free_units_o       = res_free_q;
  assign largest_free_run_o = res_run_q;
  assign owner_units_o      = res_own_q;

`ifndef SYNTH
  // the read pipeline only carries entries while a sweep is running
  a_pipe_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> (state_q == ST_SWEEP))
    else $error("sweep pipeline active outside a sweep");

  // only allocate can report a non-zero status
  a_stat_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (kind_q != ua_pkg::REQ_ALLOC)) |-> (stat_q == ua_pkg::STAT_OK))
    else $error("non-allocate request with error status");

  // the longest free run never exceeds the free count
  a_run_le_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (st.best <= st.free))
    else $error("free run longer than free count");

  // a taken request holds off the next one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one is in flight");
`endif

endmodule
